// ===== design/pbvi_pkg.sv =====
// pbvi_pkg: shared types and constants for the bezier patch volume integrator
// depends on nothing; imported by the top level
package pbvi_pkg;

    localparam int CFG_W   = 11;
    localparam int IDX_W   = 10;
    localparam int VOL_W   = 48;
    localparam int TALLY_W = 21;
    localparam int CTL_W   = 4;
    localparam int WGT_W   = 6;

    localparam logic [CFG_W-1:0] NODES_RESET = 11'd10;

    // nine times the corner, edge and inner share of a tile
    localparam logic [WGT_W-1:0] WGT_CORNER = 6'd9;
    localparam logic [WGT_W-1:0] WGT_EDGE   = 6'd18;
    localparam logic [WGT_W-1:0] WGT_INNER  = 6'd36;

    // top minus bottom control heights, first index along u
    localparam logic [CTL_W-1:0] DIFF_CTL [16] = '{
        4'd0, 4'd3, 4'd0,  4'd6,
        4'd4, 4'd2, 4'd6,  4'd0,
        4'd0, 4'd3, 4'd0,  4'd11,
        4'd0, 4'd0, 4'd10, 4'd6
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIVU,
        S_DIVV,
        S_BASIS,
        S_SUM,
        S_TERM,
        S_DIVT,
        S_OUT
    } t_state;

    function automatic logic [CTL_W-1:0] diff_ctl(input logic [1:0] i, input logic [1:0] j);
        return DIFF_CTL[{i, j}];
    endfunction

endpackage

// ===== design/pbvi_mul.sv =====
// pbvi_mul: shared unsigned multiplier with a registered product
// no dependencies
module pbvi_mul #(
    parameter int A_W = 28,
    parameter int B_W = 24
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W = A_W + B_W;

    logic [P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(i_a) * P_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== design/pbvi_div.sv =====
// pbvi_div: restoring divider, one quotient bit per cycle
// no dependencies; o_done pulses when the full quotient is on o_quo
module pbvi_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 22
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W);

    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign shifted = {r_rem, r_quo[NUM_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== design/bezier_patch_volume_integrator_top.sv =====
// bezier_patch_volume_integrator_top: sequencer, state and result register
// depends on pbvi_pkg, pbvi_mul and pbvi_div
//
//  channel   valid        ready        payload
//  input     i_valid      o_ready      i_column, i_row, i_final_node
//  result    o_valid      i_ready      o_volume, o_nodes_counted, o_index_error
//  config    i_cfg_valid  o_cfg_ready  i_cfg_data
//
// an in-range node is worked through before the next one is accepted: u, v and the weighted
// term each go through the bit-serial divider, and the 36 products share one multiplier
// an out-of-range node skips the divider and the multiplier
// a final node ends in S_OUT, which loads the result
// reset is synchronous and active low; no clearing pass
// a result waiting in the output register stalls only the next final node
module bezier_patch_volume_integrator_top
    import pbvi_pkg::*;
#(
    parameter int MAX_NODES_PER_SIDE = 1024,
    parameter int FRACTION_BITS      = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [IDX_W-1:0]          i_column,
    input  logic [IDX_W-1:0]          i_row,
    input  logic                      i_final_node,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [VOL_W-1:0]   o_volume,
    output logic [TALLY_W-1:0]        o_nodes_counted,
    output logic                      o_index_error,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    localparam int F     = FRACTION_BITS;
    localparam int DW    = $clog2(MAX_NODES_PER_SIDE);
    localparam int NCW   = (DW + 1 > CFG_W) ? DW + 1 : CFG_W;
    localparam int IW    = (DW > IDX_W) ? DW : IDX_W;
    localparam int QW    = F + 1;
    localparam int BW    = F + 2;
    localparam int SW    = F + 8;
    localparam int HW    = F + 12;
    localparam int MA    = (HW > DW) ? HW : DW;
    localparam int MB    = (SW > DW) ? SW : DW;
    localparam int PW    = MA + MB;
    localparam int NUMW  = ((HW + 6 > 2 * DW + 1) ? HW + 6 : 2 * DW + 1) + 1;
    localparam int PNUMW = IDX_W + F + 1;
    localparam int DIV_N = (NUMW > PNUMW) ? NUMW : PNUMW;
    localparam int DIV_D = 2 * DW + 2;
    localparam int AW    = ((DIV_N > VOL_W) ? DIV_N : VOL_W) + 1;

    localparam logic [PW-1:0]    HALF_P  = PW'(1) << (F - 1);
    localparam logic [QW-1:0]    ONE_Q   = QW'(1) << F;
    localparam logic [NCW-1:0]   MAX_N   = NCW'(MAX_NODES_PER_SIDE);
    localparam logic [NCW-1:0]   MIN_N   = NCW'(2);
    localparam logic [AW-1:0]    VOL_MAX = AW'({1'b0, {(VOL_W-1){1'b1}}});

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_nodes;
    logic [IDX_W-1:0]   r_col, r_row;
    logic               r_last;
    logic [DW-1:0]      r_d;
    logic [QW-1:0]      r_tu, r_tv, r_tmp;
    logic [BW-1:0]      r_bu [4];
    logic [BW-1:0]      r_bv [4];
    logic [SW-1:0]      r_s;
    logic [HW-1:0]      r_h;
    logic [2*DW-1:0]    r_dd;
    logic [2:0]         r_step;
    logic               r_axis, r_ph;
    logic [1:0]         r_i;
    logic [2:0]         r_j;
    logic [VOL_W-1:0]   r_vol;
    logic [TALLY_W-1:0] r_tally;
    logic               r_fault;
    logic               r_ovalid;
    logic [VOL_W-1:0]   r_ovol;
    logic [TALLY_W-1:0] r_ocnt;
    logic               r_oerr;

    logic [NCW-1:0]     n_ext, n_eff;
    logic [DW-1:0]      d_in;
    logic               out_rng;
    logic [QW-1:0]      t_q, w_q;
    logic [PW-1:0]      prod_rnd;
    logic [QW-1:0]      rnd_q;
    logic [BW-1:0]      rnd_x3;
    logic               edge_u, edge_v;
    logic [WGT_W-1:0]   wgt;
    logic [MA-1:0]      mul_a;
    logic [MB-1:0]      mul_b;
    logic [PW-1:0]      mul_prod;
    logic               div_start, div_done;
    logic [DIV_N-1:0]   div_num, div_quo;
    logic [DIV_D-1:0]   div_den;
    logic [AW-1:0]      acc_term, acc_vol;
    logic               load_out;

    pbvi_mul #(.A_W(MA), .B_W(MB)) u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    pbvi_div #(.NUM_W(DIV_N), .DEN_W(DIV_D)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // grid size clamped to the supported range
    always_comb begin
        n_ext = NCW'(r_nodes);
        priority if (n_ext < MIN_N) begin
            n_eff = MIN_N;
        end else if (n_ext > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = n_ext;
        end
    end
    assign d_in = DW'(n_eff - 1'b1);

    assign out_rng = (IW'(r_col) > IW'(r_d)) || (IW'(r_row) > IW'(r_d));

    assign t_q      = r_axis ? r_tv : r_tu;
    assign w_q      = ONE_Q - t_q;
    assign prod_rnd = (mul_prod + HALF_P) >> F;
    assign rnd_q    = prod_rnd[QW-1:0];
    assign rnd_x3   = {rnd_q, 1'b0} + BW'(rnd_q);

    assign edge_u = (r_col == '0) || (IW'(r_col) == IW'(r_d));
    assign edge_v = (r_row == '0) || (IW'(r_row) == IW'(r_d));
    always_comb begin
        priority if (edge_u && edge_v) begin
            wgt = WGT_CORNER;
        end else if (edge_u || edge_v) begin
            wgt = WGT_EDGE;
        end else begin
            wgt = WGT_INNER;
        end
    end

    // saturating add of the node term
    assign acc_term = AW'(div_quo);
    assign acc_vol  = (acc_term >= VOL_MAX - AW'(r_vol)) ? VOL_MAX : AW'(r_vol) + acc_term;

    assign load_out = (r_state == S_OUT) && (!r_ovalid || i_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (out_rng) begin
                    n_state = r_last ? S_OUT : S_IDLE;
                end else begin
                    n_state = S_DIVU;
                end
            end
            S_DIVU:  if (div_done) n_state = S_DIVV;
            S_DIVV:  if (div_done) n_state = S_BASIS;
            S_BASIS: if (r_ph && r_axis && r_step == 3'd6) n_state = S_SUM;
            S_SUM:   if (r_ph && r_i == 2'd3 && r_j == 3'd4) n_state = S_TERM;
            S_TERM:  if (r_ph && r_step[0]) n_state = S_DIVT;
            S_DIVT:  if (div_done) n_state = r_last ? S_OUT : S_IDLE;
            S_OUT:   if (!r_ovalid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit operands
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = DIV_D'(r_d);
        unique case (r_state)
            S_CHECK: begin
                div_start = !out_rng;
                div_num   = DIV_N'({r_col, {F{1'b0}}}) + DIV_N'(r_d >> 1);
            end
            S_DIVU: begin
                div_start = div_done;
                div_num   = DIV_N'({r_row, {F{1'b0}}}) + DIV_N'(r_d >> 1);
            end
            S_BASIS: begin
                unique case (r_step)
                    3'd0: begin mul_a = MA'(w_q);   mul_b = MB'(w_q); end
                    3'd1: begin mul_a = MA'(r_tmp); mul_b = MB'(w_q); end
                    3'd2: begin mul_a = MA'(t_q);   mul_b = MB'(w_q); end
                    3'd3: begin mul_a = MA'(r_tmp); mul_b = MB'(w_q); end
                    3'd4: begin mul_a = MA'(t_q);   mul_b = MB'(t_q); end
                    3'd5: begin mul_a = MA'(r_tmp); mul_b = MB'(w_q); end
                    3'd6: begin mul_a = MA'(r_tmp); mul_b = MB'(t_q); end
                    default: begin mul_a = '0;      mul_b = '0;       end
                endcase
            end
            S_SUM: begin
                if (r_j == 3'd4) begin
                    mul_a = MA'(r_bu[r_i]);
                    mul_b = MB'(r_s);
                end else begin
                    mul_a = MA'(r_bv[r_j[1:0]]);
                    mul_b = MB'(diff_ctl(r_i, r_j[1:0]));
                end
            end
            S_TERM: begin
                if (r_step[0]) begin
                    mul_a = MA'(r_h);
                    mul_b = MB'(wgt);
                end else begin
                    mul_a = MA'(r_d);
                    mul_b = MB'(r_d);
                end
                div_start = r_ph && r_step[0];
                div_num   = DIV_N'(mul_prod) + DIV_N'({r_dd, 1'b0});
                div_den   = {r_dd, 2'b00};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // control and accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nodes  <= NODES_RESET;
            r_step   <= '0;
            r_axis   <= 1'b0;
            r_ph     <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
            r_vol    <= '0;
            r_tally  <= '0;
            r_fault  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_nodes <= i_cfg_data;
            end

            if (r_state == S_BASIS || r_state == S_SUM || r_state == S_TERM) begin
                r_ph <= !r_ph;
            end else begin
                r_ph <= 1'b0;
            end

            unique case (r_state)
                S_DIVV: begin
                    r_step <= '0;
                    r_axis <= 1'b0;
                    r_i    <= '0;
                    r_j    <= '0;
                end
                S_BASIS: begin
                    if (r_ph) begin
                        if (r_step == 3'd6) begin
                            r_step <= '0;
                            r_axis <= 1'b1;
                        end else begin
                            r_step <= r_step + 1'b1;
                        end
                    end
                end
                S_SUM: begin
                    if (r_ph) begin
                        if (r_j == 3'd4) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                S_TERM: begin
                    if (r_ph) r_step <= r_step + 1'b1;
                end
                default: begin
                end
            endcase

            if (r_state == S_CHECK && out_rng) begin
                r_fault <= 1'b1;
            end
            if (r_state == S_DIVT && div_done) begin
                r_vol <= acc_vol[VOL_W-1:0];
                if (r_tally != '1) r_tally <= r_tally + 1'b1;
            end

            if (load_out) begin
                r_ovalid <= 1'b1;
                r_vol    <= '0;
                r_tally  <= '0;
                r_fault  <= 1'b0;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_col  <= i_column;
            r_row  <= i_row;
            r_last <= i_final_node;
            r_d    <= d_in;
        end
        if (r_state == S_CHECK) begin
            r_s <= '0;
            r_h <= '0;
        end
        if (r_state == S_DIVU && div_done) r_tu <= div_quo[QW-1:0];
        if (r_state == S_DIVV && div_done) r_tv <= div_quo[QW-1:0];

        if (r_state == S_BASIS && r_ph) begin
            unique case (r_step)
                3'd0, 3'd2, 3'd4: r_tmp <= rnd_q;
                3'd1: if (r_axis) r_bv[0] <= BW'(rnd_q); else r_bu[0] <= BW'(rnd_q);
                3'd3: if (r_axis) r_bv[1] <= rnd_x3;     else r_bu[1] <= rnd_x3;
                3'd5: if (r_axis) r_bv[2] <= rnd_x3;     else r_bu[2] <= rnd_x3;
                3'd6: if (r_axis) r_bv[3] <= BW'(rnd_q); else r_bu[3] <= BW'(rnd_q);
                default: r_tmp <= r_tmp;
            endcase
        end

        // inner sums are exact; the outer product is rounded into the height
        if (r_state == S_SUM && r_ph) begin
            if (r_j == 3'd4) begin
                r_h <= r_h + prod_rnd[HW-1:0];
                r_s <= '0;
            end else begin
                r_s <= r_s + mul_prod[SW-1:0];
            end
        end

        if (r_state == S_TERM && r_ph && !r_step[0]) begin
            r_dd <= mul_prod[2*DW-1:0];
        end

        if (load_out) begin
            r_ovol <= r_vol;
            r_ocnt <= r_tally;
            r_oerr <= r_fault;
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_volume        = $signed(r_ovol);
    assign o_nodes_counted = r_ocnt;
    assign o_index_error   = r_oerr;

`ifndef SYNTH
    // the saturating accumulator never reaches the sign bit
    a_vol_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vol[VOL_W-1])
        else $error("volume accumulator went negative");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVU || r_state == S_DIVV || r_state == S_DIVT))
        else $error("divider finished outside a divide state");

    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_CHECK))
        else $error("accepted beat not followed by range check");
`endif

endmodule
